// File: design/mstt_pkg.sv
package mstt_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 32;
  localparam int OWNER_W    = 32;
  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_CREATE     = 3'd1,
    CMD_START      = 3'd2,
    CMD_SET_PERIOD = 3'd3,
    CMD_RELOAD     = 3'd4,
    CMD_STOP       = 3'd5,
    CMD_DESTROY    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NOT_IN_USE = 2'd1,
    STS_FULL       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIRE,
    S_SCAN,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic send_fire;
    logic send_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             emit_ok;
    logic             scan_fire;
    logic             scan_last;
    logic             start_fire;
  } dp_stat_t;

endpackage

// File: design/mstt_ctrl.sv
module mstt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mstt_pkg::dp_stat_t stat,
  output mstt_pkg::dp_cmd_t  cmd
);
  import mstt_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.cmd == CMD_TICK) begin
          state_next = S_SCAN;
        end else begin
          cmd.exec   = 1'b1;
          state_next = stat.start_fire ? S_FIRE : S_DONE;
        end
      end
      S_FIRE: begin
        if (stat.emit_ok) begin
          cmd.send_fire = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_SCAN: begin
        if (!stat.scan_fire || stat.emit_ok) begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat.emit_ok) begin
          cmd.send_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.send_fire || cmd.send_status || (cmd.scan_step && stat.scan_fire)) |-> stat.emit_ok)
    else $error("Result item loaded while the output register is held.");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("Accepted item did not move to execution.");

  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.send_status |=> (state == S_IDLE))
    else $error("Final item sent without returning to idle.");

endmodule

// File: design/mstt_dp.sv
module mstt_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mstt_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [mstt_pkg::CMD_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mstt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output logic                           m_tuser,
  input  mstt_pkg::dp_cmd_t              cmd,
  output mstt_pkg::dp_stat_t             stat
);
  import mstt_pkg::*;

  logic [CMD_W-1:0]   cmd_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [OWNER_W-1:0] owner_in;
  logic [CNT_W-1:0]   period_in;
  logic [CNT_W-1:0]   delay_in;
  logic               single_in;
  logic               immediate_in;
  logic               now_in;
  logic [SLOT_W-1:0]  idx;
  status_t            status_r;
  logic [SLOT_W-1:0]  slot_res;

  logic [SLOTS-1:0]   in_use;
  logic [OWNER_W-1:0] owner_mem  [SLOTS];
  logic [CNT_W-1:0]   period_mem [SLOTS];
  logic [CNT_W-1:0]   delay_mem  [SLOTS];
  logic [CNT_W-1:0]   cnt_mem    [SLOTS];
  logic               once_mem   [SLOTS];
  logic               fas_mem    [SLOTS];

  logic               out_valid;
  logic               out_kind;
  status_t            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [OWNER_W-1:0] out_owner;
  logic               out_last;

  logic [SLOT_W-1:0]  addr;
  logic [OWNER_W-1:0] rd_owner;
  logic [CNT_W-1:0]   rd_period;
  logic [CNT_W-1:0]   rd_delay;
  logic [CNT_W-1:0]   rd_cnt;
  logic               rd_once;
  logic               rd_fas;
  logic               rd_used;
  logic [CNT_W-1:0]   dec;
  logic               run;
  logic               expire;
  logic               scan_fire;
  logic               full;
  logic [SLOT_W-1:0]  free_slot;
  logic               emit_ok;
  logic               load_fire;

  assign addr      = (cmd_r == CMD_TICK) ? idx : slot_r;
  assign rd_owner  = owner_mem[addr];
  assign rd_period = period_mem[addr];
  assign rd_delay  = delay_mem[addr];
  assign rd_cnt    = cnt_mem[addr];
  assign rd_once   = once_mem[addr];
  assign rd_fas    = fas_mem[addr];
  assign rd_used   = in_use[addr];

  assign dec       = rd_cnt - CNT_W'(1);
  assign run       = rd_used && (rd_cnt != '0);
  assign expire    = run && (dec == '0);
  assign scan_fire = expire && ((rd_delay != '0) ? rd_fas : 1'b1);

  assign full = &in_use;

  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign emit_ok   = !out_valid || m_tready;
  assign load_fire = cmd.send_fire || (cmd.scan_step && scan_fire);

  assign stat.cmd        = cmd_r;
  assign stat.emit_ok    = emit_ok;
  assign stat.scan_fire  = scan_fire;
  assign stat.scan_last  = (idx == SLOT_W'(SLOTS - 1));
  assign stat.start_fire = (cmd_r == CMD_START) && rd_used && (rd_delay == '0) && rd_fas;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r        <= s_tuser;
      slot_r       <= s_tdata[3:0];
      owner_in     <= s_tdata[35:4];
      period_in    <= s_tdata[67:36];
      delay_in     <= s_tdata[99:68];
      single_in    <= s_tdata[100];
      immediate_in <= s_tdata[101];
      now_in       <= s_tdata[102];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx      <= '0;
      status_r <= STS_OK;
      slot_res <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + SLOT_W'(1);
    end else if (cmd.exec) begin
      case (cmd_r)
        CMD_CREATE: begin
          if (full) begin
            status_r <= STS_FULL;
          end else begin
            slot_res <= free_slot;
          end
        end
        CMD_START, CMD_SET_PERIOD, CMD_RELOAD, CMD_STOP, CMD_DESTROY: begin
          if (!rd_used) begin
            status_r <= STS_NOT_IN_USE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (cmd.exec) begin
      if (cmd_r == CMD_CREATE && !full) begin
        in_use[free_slot] <= 1'b1;
      end else if (cmd_r == CMD_DESTROY) begin
        in_use[slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && run) begin
      if (!expire) begin
        cnt_mem[addr] <= dec;
      end else if (rd_delay != '0) begin
        cnt_mem[addr]   <= rd_period;
        delay_mem[addr] <= '0;
      end else begin
        cnt_mem[addr] <= rd_once ? '0 : rd_period;
      end
    end else if (cmd.exec) begin
      case (cmd_r)
        CMD_CREATE: begin
          if (!full) begin
            owner_mem[free_slot]  <= owner_in;
            period_mem[free_slot] <= period_in;
            delay_mem[free_slot]  <= delay_in;
            once_mem[free_slot]   <= single_in;
            fas_mem[free_slot]    <= immediate_in;
            cnt_mem[free_slot]    <= '0;
          end
        end
        CMD_START: begin
          if (rd_used) begin
            cnt_mem[addr] <= (rd_delay != '0) ? rd_delay : rd_period;
          end
        end
        CMD_SET_PERIOD: begin
          if (rd_used) begin
            period_mem[addr] <= period_in;
            if (now_in) begin
              cnt_mem[addr] <= period_in;
            end
          end
        end
        CMD_RELOAD: begin
          if (rd_used) begin
            cnt_mem[addr] <= rd_period;
          end
        end
        CMD_STOP: begin
          if (rd_used) begin
            cnt_mem[addr] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire || cmd.send_status) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_kind   <= 1'b1;
      out_status <= STS_OK;
      out_slot   <= addr;
      out_owner  <= rd_owner;
      out_last   <= 1'b0;
    end else if (cmd.send_status) begin
      out_kind   <= 1'b0;
      out_status <= status_r;
      out_slot   <= slot_res;
      out_owner  <= '0;
      out_last   <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_owner, out_slot, out_status};

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (!out_kind && out_owner == '0))
    else $error("Final item carries a fire event.");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind) |-> (!out_last && out_status == STS_OK))
    else $error("Fire event marked as final or with a status.");

endmodule

// File: design/multi_slot_software_timer_table.sv
// Timer table with sixteen slots, driven by one command item at a time. Every command
// item yields one final status item (tlast set); a start may first yield one fire event,
// and a tick yields one fire event, in slot order, for each slot that expires, except a
// slot ending its delay without the immediate flag. A tick is accepted, set up, walks the
// slot table one slot at a time through its single read port, and ends with the final
// item. Other commands are accepted, executed, may send one fire event, and end with the
// final item. A result item not taken downstream holds the output register and stalls the
// scan only when another item must be sent. No clearing pass is needed after reset.
module multi_slot_software_timer_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot, owner, period, delay, once, immediate, now, zero fill
  input  logic [mstt_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  logic [mstt_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, slot_out, owner_out, zero fill
  output logic [mstt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  // kind
  output logic                            m_tuser
);
  import mstt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mstt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mstt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// File: tb/tb_multi_slot_software_timer_table.sv
module tb_multi_slot_software_timer_table;
  import mstt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] owner;
    logic        last;
  } timer_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  bit          slot_busy[SLOTS];
  logic [31:0] slot_owner[SLOTS];
  logic [31:0] slot_period[SLOTS];
  logic [31:0] slot_delay[SLOTS];
  logic [31:0] slot_count[SLOTS];
  bit          slot_once[SLOTS];
  bit          slot_fire_at_start[SLOTS];

  timer_result_t results_due[$];

  int mismatches;
  int commands_sent;
  int results_seen;
  int fires_seen;
  int full_refusals;
  int unused_refusals;
  int idle_cycles;
  int hold_req;
  int hold_seen;
  int ready_wait;
  bit steady;

  multi_slot_software_timer_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic void push_result(logic kind, status_t status, logic [3:0] slot,
                                      logic [31:0] owner, logic last);
    timer_result_t item;
    item.kind   = kind;
    item.status = status;
    item.slot   = slot;
    item.owner  = owner;
    item.last   = last;
    results_due.push_back(item);
  endfunction

  function automatic void predict_command(cmd_t cmd, logic [3:0] slot, logic [31:0] owner,
                                          logic [31:0] period, logic [31:0] delay,
                                          logic once, logic imm, logic now);
    int free_slot;
    free_slot = -1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_count[i] != 0) begin
            slot_count[i] = slot_count[i] - 1;
            if (slot_count[i] == 0) begin
              if (slot_delay[i] != 0) begin
                slot_count[i] = slot_period[i];
                slot_delay[i] = '0;
                if (slot_fire_at_start[i])
                  push_result(1'b1, STS_OK, 4'(i), slot_owner[i], 1'b0);
              end else begin
                push_result(1'b1, STS_OK, 4'(i), slot_owner[i], 1'b0);
                if (!slot_once[i])
                  slot_count[i] = slot_period[i];
              end
            end
          end
        end
        push_result(1'b0, STS_OK, 4'd0, 32'd0, 1'b1);
      end
      CMD_CREATE: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i])
            free_slot = i;
        if (free_slot < 0) begin
          full_refusals++;
          push_result(1'b0, STS_FULL, 4'd0, 32'd0, 1'b1);
        end else begin
          slot_busy[free_slot]          = 1'b1;
          slot_owner[free_slot]         = owner;
          slot_period[free_slot]        = period;
          slot_delay[free_slot]         = delay;
          slot_once[free_slot]          = once;
          slot_fire_at_start[free_slot] = imm;
          slot_count[free_slot]         = '0;
          push_result(1'b0, STS_OK, 4'(free_slot), 32'd0, 1'b1);
        end
      end
      CMD_START, CMD_SET_PERIOD, CMD_RELOAD, CMD_STOP, CMD_DESTROY: begin
        if (!slot_busy[slot]) begin
          unused_refusals++;
          push_result(1'b0, STS_NOT_IN_USE, 4'd0, 32'd0, 1'b1);
        end else begin
          case (cmd)
            CMD_START: begin
              if (slot_delay[slot] != 0) begin
                slot_count[slot] = slot_delay[slot];
              end else begin
                if (slot_fire_at_start[slot])
                  push_result(1'b1, STS_OK, slot, slot_owner[slot], 1'b0);
                slot_count[slot] = slot_period[slot];
              end
            end
            CMD_SET_PERIOD: begin
              slot_period[slot] = period;
              if (now)
                slot_count[slot] = period;
            end
            CMD_RELOAD: slot_count[slot] = slot_period[slot];
            CMD_STOP: slot_count[slot] = '0;
            default: slot_busy[slot] = 1'b0;
          endcase
          push_result(1'b0, STS_OK, 4'd0, 32'd0, 1'b1);
        end
      end
      default: push_result(1'b0, STS_OK, 4'd0, 32'd0, 1'b1);
    endcase
  endfunction

  function automatic void check_result();
    timer_result_t got;
    timer_result_t want;
    got.kind   = m_tuser;
    got.status = m_tdata[1:0];
    got.slot   = m_tdata[5:2];
    got.owner  = m_tdata[37:6];
    got.last   = m_tlast;
    results_seen++;
    if (got.kind)
      fires_seen++;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind %0d status %0d slot %0d owner %h last %0d",
                 got.kind, got.status, got.slot, got.owner, got.last);
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.status !== want.status || got.slot !== want.slot ||
          got.owner !== want.owner || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind %0d status %0d slot %0d owner %h last %0d, %s",
                   want.kind, want.status, want.slot, want.owner, want.last,
                   $sformatf("got kind %0d status %0d slot %0d owner %h last %0d",
                             got.kind, got.status, got.slot, got.owner, got.last));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_result();
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls at random; a hold-off request keeps it stalled for a long stretch.
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      ready_wait <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      m_tready   <= 1'b0;
    end else if (steady || pick >= 30) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      ready_wait <= (pick < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55)
      return 0;
    if (pick < 85)
      return $urandom_range(1, 3);
    if (pick < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] pick_slot();
    int live[$];
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy[i])
        live.push_back(i);
    if (live.size() != 0 && $urandom_range(0, 99) < 85)
      return 4'(live[$urandom_range(0, live.size() - 1)]);
    return 4'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic logic [31:0] pick_span(int zero_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < zero_pct)
      return '0;
    if (pick < 85)
      return $urandom_range(1, 5);
    if (pick < 93)
      return $urandom();
    return 32'hFFFF_FFFF;
  endfunction

  task automatic send_command(cmd_t cmd, logic [3:0] slot, logic [31:0] owner,
                              logic [31:0] period, logic [31:0] delay,
                              logic once, logic imm, logic now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, now, imm, once, delay, period, owner, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(cmd, slot, owner, period, delay, once, imm, now);
    commands_sent++;
  endtask

  task automatic random_command(int tick_pct);
    int pick;
    cmd_t cmd;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      cmd = CMD_TICK;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        cmd = CMD_CREATE;
      else if (pick < 52)
        cmd = CMD_START;
      else if (pick < 66)
        cmd = CMD_SET_PERIOD;
      else if (pick < 76)
        cmd = CMD_RELOAD;
      else if (pick < 86)
        cmd = CMD_STOP;
      else
        cmd = CMD_DESTROY;
    end
    send_command(cmd, pick_slot(), $urandom, pick_span(10), pick_span(45),
                 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_table_full();
    send_command(CMD_CREATE, 4'd9, 32'h0000_0000, 32'd1, 32'd0, 1'b0, 1'b1, 1'b0);
    send_command(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 32'd2, 32'd1, 1'b1, 1'b1, 1'b1);
    send_command(CMD_CREATE, 4'd15, 32'hA5A5_A5A5, 32'd0, 32'd2, 1'b0, 1'b0, 1'b0);
    send_command(CMD_CREATE, 4'd6, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, 1'b0, 1'b1);
    for (int i = 4; i < SLOTS; i++)
      send_command(CMD_CREATE, 4'($urandom), $urandom, $urandom_range(1, 4),
                   $urandom_range(0, 3), 1'($urandom), 1'($urandom), 1'($urandom));
    send_command(CMD_CREATE, 4'd3, $urandom, 32'd1, 32'd0, 1'b0, 1'b1, 1'b0);
    send_command(CMD_DESTROY, 4'd15, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    send_command(CMD_START, 4'd15, $urandom, $urandom, $urandom, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_slot_commands();
    for (int i = 0; i < 4; i++)
      send_command(CMD_START, 4'(i), $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    repeat (3)
      send_command(CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_command(CMD_SET_PERIOD, 4'd0, $urandom, 32'd3, $urandom, 1'b0, 1'b0, 1'b1);
    send_command(CMD_SET_PERIOD, 4'd1, $urandom, 32'd5, $urandom, 1'b1, 1'b1, 1'b0);
    send_command(CMD_RELOAD, 4'd1, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    send_command(CMD_STOP, 4'd0, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    repeat (2)
      send_command(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_mix(int count);
    repeat (count)
      random_command(40);
  endtask

  task automatic test_output_hold_off();
    hold_req <= hold_req + 1;
    repeat (30)
      random_command(70);
  endtask

  task automatic test_steady_stream();
    steady <= 1'b1;
    repeat (40)
      random_command(40);
    steady <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_full();
    test_slot_commands();
    test_random_mix(120);
    test_output_hold_off();
    test_steady_stream();
    test_random_mix(90);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands and checked %0d result items, %0d of them timer fires.",
             commands_sent, results_seen, fires_seen);
    $display("Refused %0d creates on a full table and %0d commands on unused slots.",
             full_refusals, unused_refusals);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
